// ===== rtl/rmer_pkg.sv =====
// Shared codes and types for the rotated midpoint ellipse rasterizer.
package rmer_pkg;

  // Input word kinds, carried on tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Configuration register indexes
  localparam logic REG_SIN = 1'b0;
  localparam logic REG_COS = 1'b1;

  // Operand negation flags for one rounded placement
  typedef struct packed {
    logic neg_a;
    logic neg_b;
  } rmer_sign_t;

endpackage

// ===== rtl/rmer_place.sv =====
// Rotated coordinate placement: add centre and a half, truncate toward zero, saturate.
module rmer_place #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 14,
  parameter int IN_BITS    = 28
) (
  input  logic [COORD_BITS-1:0]        centre_i,
  input  logic signed [IN_BITS-1:0]    a_i,
  input  logic signed [IN_BITS-1:0]    b_i,
  input  rmer_pkg::rmer_sign_t         sign_i,
  output logic signed [COORD_BITS+2:0] coord_o
);
  import rmer_pkg::*;

  localparam int VW = IN_BITS + 3;
  localparam int OW = COORD_BITS + 3;

  logic signed [VW-1:0] a_ext, b_ext, ctr_ext, v, mag, r;
  logic signed [VW-1:0] lo, hi;

  // Sum the two products with the scaled centre and the rounding half; truncate and saturate
  always_comb begin
    a_ext   = sign_i.neg_a ? -VW'(a_i) : VW'(a_i);
    b_ext   = sign_i.neg_b ? -VW'(b_i) : VW'(b_i);
    ctr_ext = VW'(signed'({1'b0, centre_i})) <<< FRAC_BITS;
    v       = a_ext + b_ext + ctr_ext + (VW'(1) <<< (FRAC_BITS - 1));
    mag     = v[VW-1] ? -v : v;
    r       = v[VW-1] ? -(mag >>> FRAC_BITS) : (v >>> FRAC_BITS);
    lo      = -(VW'(1) <<< (OW - 1));
    hi      = (VW'(1) <<< (OW - 1)) - VW'(1);
    if (r < lo) begin
      coord_o = OW'(lo);
    end else if (r > hi) begin
      coord_o = OW'(hi);
    end else begin
      coord_o = OW'(r);
    end
  end

endmodule

// ===== rtl/rotated_midpoint_ellipse_raster.sv =====
// Top level of the rotated midpoint ellipse rasterizer with its shared multiplier sequencer.
//
// channel   | direction | handshake                     | payload
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tuser opcode, tdata coordinates
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tuser valid_res, tlast, tdata points
// cfg       | in        | cfg_we_i                      | cfg_idx_i, cfg_data_i
//
// One multiplier serves all products, one per cycle while busy. A start word runs SQX, SQY,
// DEC0; a region one step P1, P2; a step into region two P1, P2, Q1-Q5, R2; a region two
// step P1, P2, R2; each then RA-RD, OUT. An idle step goes straight to OUT. Reset clears
// control and configures sine 0, cosine 1.0. The sequencer waits in its final state while an
// earlier result is still unread; a new word is taken once the sequencer is back in idle.
module rotated_midpoint_ellipse_raster #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // centre_x, centre_y, corner_x, corner_y from bit 0 up, zero filled
  input  logic [((4*COORD_BITS)+7)/8*8-1:0]         s_axis_tdata,
  // opcode
  input  logic                                      s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y from bit 0 up, zero filled
  output logic [((8*(COORD_BITS+3))+7)/8*8-1:0]     m_axis_tdata,
  // valid_res
  output logic                                      m_axis_tuser,
  output logic                                      m_axis_tlast,
  input  logic                                      cfg_we_i,
  input  logic                                      cfg_idx_i,
  input  logic [FRAC_BITS+1:0]                      cfg_data_i
);
  import rmer_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int RW   = FRAC_BITS + 2;
  localparam int XW   = CB + 1;
  localparam int SQW  = 2 * CB;
  localparam int MW   = (2 * CB + 4 > RW) ? 2 * CB + 4 : RW;
  localparam int PW   = 2 * MW;
  localparam int DW   = 4 * CB + 8;
  localparam int PRW  = CB + RW + 1;
  localparam int OW   = CB + 3;
  localparam int IDW  = ((4 * CB) + 7) / 8 * 8;
  localparam int ODW  = ((8 * OW) + 7) / 8 * 8;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SQX  = 5'd1;
  localparam logic [4:0] S_SQY  = 5'd2;
  localparam logic [4:0] S_DEC0 = 5'd3;
  localparam logic [4:0] S_P1   = 5'd4;
  localparam logic [4:0] S_P2   = 5'd5;
  localparam logic [4:0] S_Q1   = 5'd6;
  localparam logic [4:0] S_Q2   = 5'd7;
  localparam logic [4:0] S_Q3   = 5'd8;
  localparam logic [4:0] S_Q4   = 5'd9;
  localparam logic [4:0] S_Q5   = 5'd10;
  localparam logic [4:0] S_R2   = 5'd11;
  localparam logic [4:0] S_RA   = 5'd12;
  localparam logic [4:0] S_RB   = 5'd13;
  localparam logic [4:0] S_RC   = 5'd14;
  localparam logic [4:0] S_RD   = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  logic [4:0]             state_q, state_d;
  logic signed [RW-1:0]   sin_q, cos_q;
  logic                   active_q, reg2_q, last_q, zero_q;
  logic [CB-1:0]          cx_q, cy_q, rx_q, ry_q;
  logic [SQW-1:0]         sqx_q, sqy_q;
  logic [XW-1:0]          x_q, y_q;
  logic [DW-1:0]          dec_q;
  logic signed [PW-1:0]   p1_q, p2_q;
  logic signed [MW-1:0]   q_q;
  logic signed [PRW-1:0]  ra_q, rb_q, rc_q, rd_q;
  logic                   m_valid_q, m_user_q, m_last_q;
  logic [ODW-1:0]         m_data_q;

  logic signed [MW-1:0]   op_a, op_b;
  logic signed [PW-1:0]   prod;
  logic [CB-1:0]          in_cx, in_cy, in_ex, in_ey;
  logic                   accept, out_free;
  logic [DW-1:0]          t8p1, t8p2, t12sqx, t12sqy, t8sqx, t8sqy;
  logic [XW-1:0]          y_dec;
  logic [XW:0]            x2p1;
  logic signed [OW-1:0]   pt [8];
  logic [8*OW-1:0]        pts;

  assign in_cx  = s_axis_tdata[CB-1:0];
  assign in_cy  = s_axis_tdata[2*CB-1:CB];
  assign in_ex  = s_axis_tdata[3*CB-1:2*CB];
  assign in_ey  = s_axis_tdata[4*CB-1:3*CB];
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = m_data_q;

  // Pick operands for the shared multiplier
  assign x2p1  = {x_q, 1'b1};
  assign y_dec = y_q - XW'(1);
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      S_SQX: begin
        op_a = MW'(signed'({1'b0, rx_q}));
        op_b = MW'(signed'({1'b0, rx_q}));
      end
      S_SQY: begin
        op_a = MW'(signed'({1'b0, ry_q}));
        op_b = MW'(signed'({1'b0, ry_q}));
      end
      S_DEC0: begin
        op_a = MW'(signed'({1'b0, sqx_q}));
        op_b = MW'(signed'({1'b0, ry_q}));
      end
      S_P1: begin
        op_a = MW'(signed'({1'b0, sqy_q}));
        op_b = MW'(signed'({1'b0, x_q}));
      end
      S_P2: begin
        op_a = MW'(signed'({1'b0, sqx_q}));
        op_b = MW'(signed'({1'b0, y_q}));
      end
      S_Q1: begin
        op_a = MW'(signed'({1'b0, x2p1}));
        op_b = MW'(signed'({1'b0, x2p1}));
      end
      S_Q2: begin
        op_a = MW'(signed'({1'b0, sqy_q}));
        op_b = q_q;
      end
      S_Q3: begin
        op_a = MW'(signed'({1'b0, y_dec}));
        op_b = MW'(signed'({1'b0, y_dec}));
      end
      S_Q4: begin
        op_a = MW'(signed'({1'b0, sqx_q}));
        op_b = q_q;
      end
      S_Q5: begin
        op_a = MW'(signed'({1'b0, sqx_q}));
        op_b = MW'(signed'({1'b0, sqy_q}));
      end
      S_RA: begin
        op_a = MW'(signed'({1'b0, x_q}));
        op_b = MW'(cos_q);
      end
      S_RB: begin
        op_a = MW'(signed'({1'b0, y_q}));
        op_b = MW'(sin_q);
      end
      S_RC: begin
        op_a = MW'(signed'({1'b0, x_q}));
        op_b = MW'(sin_q);
      end
      S_RD: begin
        op_a = MW'(signed'({1'b0, y_q}));
        op_b = MW'(cos_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end
  assign prod = op_a * op_b;

  // Scaled decision terms
  assign t8p1   = DW'(p1_q) << 3;
  assign t8p2   = DW'(p2_q) << 3;
  assign t8sqx  = DW'(sqx_q) << 3;
  assign t8sqy  = DW'(sqy_q) << 3;
  assign t12sqx = (DW'(sqx_q) << 3) + (DW'(sqx_q) << 2);
  assign t12sqy = (DW'(sqy_q) << 3) + (DW'(sqy_q) << 2);

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == OP_START) begin
            state_d = S_SQX;
          end else if (active_q) begin
            state_d = S_P1;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_SQX:  state_d = S_SQY;
      S_SQY:  state_d = S_DEC0;
      S_DEC0: state_d = S_RA;
      S_P1:   state_d = S_P2;
      S_P2: begin
        if (reg2_q) begin
          state_d = S_R2;
        end else if (p1_q <= prod && {1'b0, rx_q} > x_q) begin
          state_d = S_RA;
        end else begin
          state_d = S_Q1;
        end
      end
      S_Q1:   state_d = S_Q2;
      S_Q2:   state_d = S_Q3;
      S_Q3:   state_d = S_Q4;
      S_Q4:   state_d = S_Q5;
      S_Q5:   state_d = S_R2;
      S_R2:   state_d = S_RA;
      S_RA:   state_d = S_RB;
      S_RB:   state_d = S_RC;
      S_RC:   state_d = S_RD;
      S_RD:   state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sin_q     <= '0;
      cos_q     <= RW'(1) <<< FRAC_BITS;
      active_q  <= 1'b0;
      reg2_q    <= 1'b0;
      last_q    <= 1'b0;
      zero_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SIN) begin
          sin_q <= cfg_data_i;
        end else begin
          cos_q <= cfg_data_i;
        end
      end
      // Load a new result word, or drop the one just taken
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (s_axis_tuser == OP_START) begin
              reg2_q <= 1'b0;
              zero_q <= 1'b0;
            end else begin
              zero_q <= !active_q;
            end
          end
        end
        S_DEC0: begin
          last_q   <= (ry_q == '0);
          active_q <= (ry_q != '0);
        end
        S_P2: begin
          if (!reg2_q && p1_q <= prod && {1'b0, rx_q} > x_q) begin
            if (dec_q[DW-1]) begin
              last_q   <= (y_q == '0);
              active_q <= (y_q != '0);
            end else begin
              last_q   <= (y_dec == '0);
              active_q <= (y_dec != '0);
            end
          end else begin
            reg2_q <= 1'b1;
          end
        end
        S_R2: begin
          last_q   <= (y_dec == '0);
          active_q <= (y_dec != '0);
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the walk payload and the products
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept && s_axis_tuser == OP_START) begin
          cx_q <= in_cx;
          cy_q <= in_cy;
          rx_q <= (in_ex >= in_cx) ? in_ex - in_cx : in_cx - in_ex;
          ry_q <= (in_ey >= in_cy) ? in_ey - in_cy : in_cy - in_ey;
          x_q  <= '0;
          y_q  <= XW'((in_ey >= in_cy) ? in_ey - in_cy : in_cy - in_ey);
        end
      end
      S_SQX: sqx_q <= SQW'(prod);
      S_SQY: sqy_q <= SQW'(prod);
      S_DEC0: dec_q <= (DW'(sqy_q) << 2) - (DW'(prod) << 2) + DW'(sqx_q);
      S_P1: p1_q <= prod;
      S_P2: begin
        p2_q <= prod;
        if (!reg2_q && p1_q <= prod && {1'b0, rx_q} > x_q) begin
          x_q <= x_q + XW'(1);
          if (dec_q[DW-1]) begin
            dec_q <= dec_q + t8p1 + t12sqy;
          end else begin
            dec_q <= dec_q + t8p1 + t12sqy + t8sqx - (DW'(prod) << 3);
            y_q   <= y_dec;
          end
        end
      end
      S_Q1: q_q <= MW'(prod);
      S_Q2: dec_q <= DW'(prod);
      S_Q3: q_q <= MW'(prod);
      S_Q4: dec_q <= dec_q + (DW'(prod) << 2);
      S_Q5: dec_q <= dec_q - (DW'(prod) << 2);
      S_R2: begin
        y_q <= y_dec;
        if (!dec_q[DW-1]) begin
          dec_q <= dec_q + t12sqx - t8p2;
        end else begin
          dec_q <= dec_q + t8p1 + t12sqx + t8sqy - t8p2;
          x_q   <= x_q + XW'(1);
        end
      end
      S_RA: ra_q <= PRW'(prod);
      S_RB: rb_q <= PRW'(prod);
      S_RC: rc_q <= PRW'(prod);
      S_RD: rd_q <= PRW'(prod);
      S_OUT: begin
        if (out_free) begin
          m_user_q <= !zero_q;
          m_last_q <= zero_q ? 1'b0 : last_q;
          m_data_q <= zero_q ? '0 : ODW'(pts);
        end
      end
      default: begin
      end
    endcase
  end

  // Place the four symmetric points: x terms (+-A, +-B), y terms (+-C, +-D)
  rmer_place #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS), .IN_BITS(PRW)) u_pa_x (
    .centre_i(cx_q), .a_i(ra_q), .b_i(rb_q), .sign_i('{neg_a: 1'b0, neg_b: 1'b1}),
    .coord_o(pt[0]));
  rmer_place #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS), .IN_BITS(PRW)) u_pa_y (
    .centre_i(cy_q), .a_i(rc_q), .b_i(rd_q), .sign_i('{neg_a: 1'b0, neg_b: 1'b0}),
    .coord_o(pt[1]));
  rmer_place #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS), .IN_BITS(PRW)) u_pb_x (
    .centre_i(cx_q), .a_i(ra_q), .b_i(rb_q), .sign_i('{neg_a: 1'b0, neg_b: 1'b0}),
    .coord_o(pt[2]));
  rmer_place #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS), .IN_BITS(PRW)) u_pb_y (
    .centre_i(cy_q), .a_i(rc_q), .b_i(rd_q), .sign_i('{neg_a: 1'b0, neg_b: 1'b1}),
    .coord_o(pt[3]));
  rmer_place #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS), .IN_BITS(PRW)) u_pc_x (
    .centre_i(cx_q), .a_i(ra_q), .b_i(rb_q), .sign_i('{neg_a: 1'b1, neg_b: 1'b1}),
    .coord_o(pt[4]));
  rmer_place #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS), .IN_BITS(PRW)) u_pc_y (
    .centre_i(cy_q), .a_i(rc_q), .b_i(rd_q), .sign_i('{neg_a: 1'b1, neg_b: 1'b0}),
    .coord_o(pt[5]));
  rmer_place #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS), .IN_BITS(PRW)) u_pd_x (
    .centre_i(cx_q), .a_i(ra_q), .b_i(rb_q), .sign_i('{neg_a: 1'b1, neg_b: 1'b0}),
    .coord_o(pt[6]));
  rmer_place #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS), .IN_BITS(PRW)) u_pd_y (
    .centre_i(cy_q), .a_i(rc_q), .b_i(rd_q), .sign_i('{neg_a: 1'b1, neg_b: 1'b1}),
    .coord_o(pt[7]));

  assign pts = {pt[7], pt[6], pt[5], pt[4], pt[3], pt[2], pt[1], pt[0]};

endmodule
